### hdl/flvd_pkg.sv
package flvd_pkg;

  // Unit byte positions and length arithmetic
  localparam int IDX_W          = 25;
  localparam int HDR_IDX_W      = 4;
  localparam int TAG_HDR_LAST   = 10;
  localparam int BODY_FIRST_IDX = 11;
  localparam int HDR_LAST       = 12;
  localparam int TAG_TAIL_OFS   = 14;
  localparam int TAG_OVERHEAD   = 15;
  localparam int TRAILER_OFS    = 4;
  localparam int SUM_W          = 33;

  localparam logic [7:0] CHAR_F      = 8'h46;
  localparam logic [7:0] CHAR_L      = 8'h4c;
  localparam logic [7:0] CHAR_V      = 8'h56;
  localparam logic [7:0] HDR_MARK    = 8'h09;
  localparam logic [7:0] VIDEO_TAG   = 8'h09;
  localparam logic [3:0] KEY_FRAME   = 4'h1;

  localparam logic [HDR_IDX_W-1:0] IDX_SIG0    = 4'd0;
  localparam logic [HDR_IDX_W-1:0] IDX_SIG1    = 4'd1;
  localparam logic [HDR_IDX_W-1:0] IDX_SIG2    = 4'd2;
  localparam logic [HDR_IDX_W-1:0] IDX_VERSION = 4'd3;
  localparam logic [HDR_IDX_W-1:0] IDX_FLAGS   = 4'd4;
  localparam logic [HDR_IDX_W-1:0] IDX_MARK    = 4'd8;
  localparam logic [HDR_IDX_W-1:0] IDX_PAD     = 4'd9;

  // Result queue between parser and output stage
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;
  localparam int QUEUE_CNT_W = 3;

  typedef enum logic [1:0] {
    OUT_HDR_OK  = 2'd0,
    OUT_TAG_OK  = 2'd1,
    OUT_HDR_BAD = 2'd2,
    OUT_TAG_BAD = 2'd3
  } flvd_outcome_e;

  typedef struct packed {
    logic        is_stream;
    logic        good;
    logic [7:0]  tag_type;
    logic [23:0] data_size;
    logic        keyframe;
    logic [7:0]  version;
    logic [7:0]  flags;
    logic [31:0] trailer;
  } flvd_rec_t;

endpackage

### hdl/flvd_front.sv
module flvd_front import flvd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       byte_valid_i,
  input  logic [7:0] byte_i,
  output logic       rec_push_o,
  output flvd_rec_t  rec_o
);

  logic                 in_body_q, in_body_d;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic                 is_hdr_q, is_hdr_d;
  logic                 good_q, good_d;
  logic                 halted_q, halted_d;
  logic [7:0]           tag_type_q, tag_type_d;
  logic [23:0]          size_q, size_d;
  logic                 key_q, key_d;
  logic [31:0]          trail_q, trail_d;
  logic [7:0]           ver_q, ver_d;
  logic [7:0]           flags_q, flags_d;

  logic [HDR_IDX_W-1:0] hdr_idx;
  logic [SUM_W-1:0]     trail_sum;
  logic [SUM_W-1:0]     len_sum;
  logic                 tag_ok;
  logic                 body_last;

  assign hdr_idx   = idx_q[HDR_IDX_W-1:0];
  assign body_last = (idx_q == (IDX_W'(size_q) + IDX_W'(TAG_TAIL_OFS)));

  always_comb begin
    in_body_d  = in_body_q;
    idx_d      = idx_q;
    is_hdr_d   = is_hdr_q;
    good_d     = good_q;
    halted_d   = halted_q;
    tag_type_d = tag_type_q;
    size_d     = size_q;
    key_d      = key_q;
    trail_d    = trail_q;
    ver_d      = ver_q;
    flags_d    = flags_q;
    rec_push_o = 1'b0;
    trail_sum  = '0;
    len_sum    = '0;
    tag_ok     = 1'b0;

    if (byte_valid_i && !halted_q) begin
      if (!in_body_q) begin
        case (hdr_idx)
          IDX_SIG0: begin
            is_hdr_d   = (byte_i == CHAR_F);
            good_d     = 1'b1;
            tag_type_d = byte_i;
            size_d     = '0;
            key_d      = 1'b0;
          end
          IDX_SIG1:    is_hdr_d = is_hdr_q & (byte_i == CHAR_L);
          IDX_SIG2:    is_hdr_d = is_hdr_q & (byte_i == CHAR_V);
          IDX_VERSION: ver_d    = byte_i;
          IDX_FLAGS:   flags_d  = byte_i;
          IDX_MARK:    good_d   = (byte_i == HDR_MARK);
          default: begin
            if (hdr_idx >= IDX_PAD) good_d = good_q & (byte_i == 8'd0);
          end
        endcase
        // size field sits in bytes one to three of a tag header
        if (hdr_idx >= IDX_SIG1 && hdr_idx <= IDX_VERSION) begin
          size_d = {size_q[15:0], byte_i};
        end

        if (idx_q == IDX_W'(TAG_HDR_LAST) && !is_hdr_q) begin
          in_body_d = 1'b1;
          idx_d     = IDX_W'(BODY_FIRST_IDX);
        end else if (idx_q == IDX_W'(HDR_LAST)) begin
          rec_push_o = 1'b1;
          halted_d   = !good_d;
          idx_d      = '0;
          trail_d    = '0;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end else begin
        if (idx_q == IDX_W'(BODY_FIRST_IDX)) begin
          key_d = (tag_type_q == VIDEO_TAG) && (byte_i[7:4] == KEY_FRAME);
        end
        trail_d   = {trail_q[23:0], byte_i};
        trail_sum = SUM_W'(trail_d) + SUM_W'(TRAILER_OFS);
        len_sum   = SUM_W'(size_q) + SUM_W'(TAG_OVERHEAD);
        tag_ok    = (trail_sum == len_sum);
        if (body_last) begin
          rec_push_o = 1'b1;
          halted_d   = !tag_ok;
          in_body_d  = 1'b0;
          idx_d      = '0;
          trail_d    = '0;
        end else begin
          idx_d = idx_q + IDX_W'(1);
        end
      end
    end

    rec_o.is_stream = !in_body_q;
    rec_o.good      = in_body_q ? tag_ok : good_d;
    rec_o.tag_type  = tag_type_q;
    rec_o.data_size = size_q;
    rec_o.keyframe  = key_d;
    rec_o.version   = ver_q;
    rec_o.flags     = flags_q;
    rec_o.trailer   = {trail_q[23:0], byte_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_body_q  <= 1'b0;
      idx_q      <= '0;
      is_hdr_q   <= 1'b0;
      good_q     <= 1'b1;
      halted_q   <= 1'b0;
      tag_type_q <= '0;
      size_q     <= '0;
      key_q      <= 1'b0;
      trail_q    <= '0;
      ver_q      <= '0;
      flags_q    <= '0;
    end else begin
      in_body_q  <= in_body_d;
      idx_q      <= idx_d;
      is_hdr_q   <= is_hdr_d;
      good_q     <= good_d;
      halted_q   <= halted_d;
      tag_type_q <= tag_type_d;
      size_q     <= size_d;
      key_q      <= key_d;
      trail_q    <= trail_d;
      ver_q      <= ver_d;
      flags_q    <= flags_d;
    end
  end

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> !rec_push_o)
    else $error("result produced while halted");

  a_bad_halts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rec_push_o && !rec_o.good |=> halted_q)
    else $error("failed unit did not halt the parser");

  a_body_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_body_q |-> idx_q >= IDX_W'(BODY_FIRST_IDX))
    else $error("body byte index below first body position");

endmodule

### hdl/flvd_queue.sv
module flvd_queue import flvd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  flvd_rec_t rec_i,
  output logic      full_o,
  input  logic      take_i,
  output logic      empty_o,
  output flvd_rec_t rec_o
);

  flvd_rec_t              mem_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_CNT_W-1:0] cnt_q, cnt_d;
  logic                   do_wr;
  logic                   do_rd;

  assign full_o  = (cnt_q == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign rec_o   = mem_q[rd_ptr_q];
  assign do_wr   = push_i && !full_o;
  assign do_rd   = take_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_wr ? wr_ptr_q + QUEUE_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = do_rd ? rd_ptr_q + QUEUE_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr && !do_rd) cnt_d = cnt_q + QUEUE_CNT_W'(1);
    if (do_rd && !do_wr) cnt_d = cnt_q - QUEUE_CNT_W'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= rec_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QUEUE_CNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> !push_i)
    else $error("record pushed into full queue");

endmodule

### hdl/flvd_back.sv
module flvd_back import flvd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  flvd_rec_t   q_rec_i,
  output logic        q_take_o,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [1:0]  outcome_o,
  output logic [7:0]  tag_type_o,
  output logic [23:0] data_size_o,
  output logic        keyframe_o,
  output logic [7:0]  stream_version_o,
  output logic [7:0]  stream_flags_o,
  output logic [31:0] trailer_size_o
);

  logic          valid_q, valid_d;
  flvd_outcome_e outcome_q, outcome_d;
  logic [7:0]    tag_type_q, tag_type_d;
  logic [23:0]   size_q, size_d;
  logic          key_q, key_d;
  logic [7:0]    ver_q, ver_d;
  logic [7:0]    flags_q, flags_d;
  logic [31:0]   trail_q, trail_d;

  // refill the output beat whenever it is free or leaving
  assign q_take_o = !q_empty_i && (!valid_q || pop_i);

  always_comb begin
    valid_d    = valid_q;
    outcome_d  = outcome_q;
    tag_type_d = tag_type_q;
    size_d     = size_q;
    key_d      = key_q;
    ver_d      = ver_q;
    flags_d    = flags_q;
    trail_d    = trail_q;
    if (valid_q && pop_i) valid_d = 1'b0;
    if (q_take_o) begin
      valid_d = 1'b1;
      if (q_rec_i.is_stream) begin
        outcome_d  = q_rec_i.good ? OUT_HDR_OK : OUT_HDR_BAD;
        tag_type_d = '0;
        size_d     = '0;
        key_d      = 1'b0;
        ver_d      = q_rec_i.version;
        flags_d    = q_rec_i.flags;
        trail_d    = '0;
      end else begin
        outcome_d  = q_rec_i.good ? OUT_TAG_OK : OUT_TAG_BAD;
        tag_type_d = q_rec_i.tag_type;
        size_d     = q_rec_i.data_size;
        key_d      = q_rec_i.keyframe;
        ver_d      = '0;
        flags_d    = '0;
        trail_d    = q_rec_i.trailer;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    outcome_q  <= outcome_d;
    tag_type_q <= tag_type_d;
    size_q     <= size_d;
    key_q      <= key_d;
    ver_q      <= ver_d;
    flags_q    <= flags_d;
    trail_q    <= trail_d;
  end

  assign empty_o          = !valid_q;
  assign outcome_o        = outcome_q;
  assign tag_type_o       = tag_type_q;
  assign data_size_o      = size_q;
  assign keyframe_o       = key_q;
  assign stream_version_o = ver_q;
  assign stream_flags_o   = flags_q;
  assign trailer_size_o   = trail_q;

endmodule

### hdl/flv_tag_deframer.sv
// Channel   | Handshake          | Beat contents
// ----------+--------------------+---------------------------------------------
// bytes in  | push / full        | stream_byte_i
// results   | empty / pop        | outcome_o, tag_type_o, data_size_o,
//           |                    | keyframe_o, stream_version_o,
//           |                    | stream_flags_o, trailer_size_o
//
// One byte is taken every cycle while full is low; the parser writes a result
// into the result queue at the edge that takes the last byte of its unit, and
// the output register loads it once the output beat is empty or being popped.
// full rises only when the result queue holds four unread results.
// Reset (rst_ni low, asynchronous) clears the parser, queue and output valid flag.
// After a bad stream header or a tag length mismatch every byte is dropped
// until reset.
module flv_tag_deframer import flvd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  stream_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  outcome_o,
  output logic [7:0]  tag_type_o,
  output logic [23:0] data_size_o,
  output logic        keyframe_o,
  output logic [7:0]  stream_version_o,
  output logic [7:0]  stream_flags_o,
  output logic [31:0] trailer_size_o
);

  logic      byte_valid;
  logic      rec_push;
  flvd_rec_t rec_in;
  flvd_rec_t rec_head;
  logic      q_full;
  logic      q_empty;
  logic      q_take;

  assign full       = q_full;
  assign byte_valid = push && !q_full;

  flvd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (byte_valid),
    .byte_i       (stream_byte_i),
    .rec_push_o   (rec_push),
    .rec_o        (rec_in)
  );

  flvd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rec_push),
    .rec_i   (rec_in),
    .full_o  (q_full),
    .take_i  (q_take),
    .empty_o (q_empty),
    .rec_o   (rec_head)
  );

  flvd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_rec_i          (rec_head),
    .q_take_o         (q_take),
    .pop_i            (pop),
    .empty_o          (empty),
    .outcome_o        (outcome_o),
    .tag_type_o       (tag_type_o),
    .data_size_o      (data_size_o),
    .keyframe_o       (keyframe_o),
    .stream_version_o (stream_version_o),
    .stream_flags_o   (stream_flags_o),
    .trailer_size_o   (trailer_size_o)
  );

endmodule

### dv/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import flvd_pkg::*;

  localparam logic [7:0] AUDIO_TAG  = 8'h08;
  localparam logic [7:0] SCRIPT_TAG = 8'h12;
  localparam int         MAX_SHOWN  = 10;

  typedef struct {
    flvd_outcome_e outcome;
    logic [7:0]    tag_type;
    logic [23:0]   data_size;
    logic          keyframe;
    logic [7:0]    version;
    logic [7:0]    flags;
    logic [31:0]   trailer;
  } unit_report_t;

  typedef enum {BREAK_MARK, BREAK_PAD, BREAK_TRAILER, BREAK_TRAILER_MAX} break_e;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        push        = 1'b0;
  logic        full;
  logic [7:0]  stream_byte = 8'h00;
  logic        empty;
  logic        pop         = 1'b0;
  logic [1:0]  outcome;
  logic [7:0]  tag_type;
  logic [23:0] data_size;
  logic        keyframe;
  logic [7:0]  stream_version;
  logic [7:0]  stream_flags;
  logic [31:0] trailer_size;

  // Parser state, mirrored from the byte stream
  bit          unit_open   = 1'b0;
  logic [24:0] unit_pos    = '0;
  bit          looks_flv   = 1'b0;
  bit          hdr_valid   = 1'b1;
  bit          stopped     = 1'b0;
  logic [7:0]  cur_type    = '0;
  logic [23:0] cur_size    = '0;
  bit          cur_key     = 1'b0;
  logic [31:0] tail_word   = '0;
  logic [7:0]  cur_version = '0;
  logic [7:0]  cur_flags   = '0;

  unit_report_t unit_reports[$];

  int     bytes_sent    = 0;
  int     reports_made  = 0;
  int     reports_seen  = 0;
  int     hdr_seen      = 0;
  int     tag_seen      = 0;
  int     key_seen      = 0;
  int     dropped_bytes = 0;
  int     errors        = 0;
  bit     tx_idle       = 1'b1;
  bit     rx_idle       = 1'b1;
  int     rx_hold       = 0;
  break_e closing_break = BREAK_MARK;

  flv_tag_deframer DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push             (push),
    .full             (full),
    .stream_byte_i    (stream_byte),
    .empty            (empty),
    .pop              (pop),
    .outcome_o        (outcome),
    .tag_type_o       (tag_type),
    .data_size_o      (data_size),
    .keyframe_o       (keyframe),
    .stream_version_o (stream_version),
    .stream_flags_o   (stream_flags),
    .trailer_size_o   (trailer_size)
  );

  always #5 clk_i = ~clk_i;

  function automatic int idle_gap(input bit enabled);
    int r;
    if (!enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [31:0] good_trailer(input int size);
    return 32'(size + TAG_OVERHEAD - TRAILER_OFS);
  endfunction

  task automatic close_unit(input unit_report_t r);
    unit_open = 1'b0;
    unit_pos  = '0;
    tail_word = '0;
    unit_reports.push_back(r);
    reports_made++;
  endtask

  task automatic deframe_byte(input logic [7:0] b);
    unit_report_t r;
    logic [24:0]  idx;
    logic [32:0]  total;
    logic [32:0]  sum;
    idx = unit_pos;
    if (stopped) begin
      dropped_bytes++;
      return;
    end
    if (!unit_open) begin
      case (idx)
        IDX_SIG0: begin
          looks_flv = (b == CHAR_F);
          hdr_valid = 1'b1;
          cur_type  = b;
          cur_size  = '0;
          cur_key   = 1'b0;
        end
        IDX_SIG1:    looks_flv = looks_flv & (b == CHAR_L);
        IDX_SIG2:    looks_flv = looks_flv & (b == CHAR_V);
        IDX_VERSION: cur_version = b;
        IDX_FLAGS:   cur_flags = b;
        IDX_MARK:    hdr_valid = (b == HDR_MARK);
        default: begin
          if (idx >= IDX_PAD) hdr_valid = hdr_valid & (b == 8'h00);
        end
      endcase
      if (idx >= IDX_SIG1 && idx <= IDX_VERSION) cur_size = {cur_size[15:0], b};
      if (idx == TAG_HDR_LAST && !looks_flv) begin
        unit_open = 1'b1;
        unit_pos  = 25'(BODY_FIRST_IDX);
        return;
      end
      if (idx == HDR_LAST) begin
        r.outcome   = hdr_valid ? OUT_HDR_OK : OUT_HDR_BAD;
        r.tag_type  = '0;
        r.data_size = '0;
        r.keyframe  = 1'b0;
        r.version   = cur_version;
        r.flags     = cur_flags;
        r.trailer   = '0;
        stopped     = !hdr_valid;
        close_unit(r);
        return;
      end
      unit_pos = idx + 25'd1;
      return;
    end
    // first body byte carries the frame type nibble of a video tag
    if (idx == BODY_FIRST_IDX) cur_key = (cur_type == VIDEO_TAG) && (b[7:4] == KEY_FRAME);
    tail_word = {tail_word[23:0], b};
    if (idx == {1'b0, cur_size} + 25'(TAG_TAIL_OFS)) begin
      total       = {9'd0, cur_size} + 33'(TAG_OVERHEAD);
      sum         = {1'b0, tail_word} + 33'(TRAILER_OFS);
      r.outcome   = (sum == total) ? OUT_TAG_OK : OUT_TAG_BAD;
      r.tag_type  = cur_type;
      r.data_size = cur_size;
      r.keyframe  = cur_key;
      r.version   = '0;
      r.flags     = '0;
      r.trailer   = tail_word;
      stopped     = (sum != total);
      close_unit(r);
      return;
    end
    unit_pos = idx + 25'd1;
  endtask

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = idle_gap(tx_idle);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push        <= 1'b1;
    stream_byte <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    bytes_sent++;
    deframe_byte(b);
  endtask

  task automatic send_flv_header(input logic [7:0] ver, input logic [7:0] flg,
                                 input logic [7:0] mark, input int pad_at,
                                 input logic [7:0] pad_val);
    int k;
    send_byte(CHAR_F);
    send_byte(CHAR_L);
    send_byte(CHAR_V);
    send_byte(ver);
    send_byte(flg);
    for (k = 5; k < 8; k++) send_byte(8'($urandom));
    send_byte(mark);
    for (k = 9; k <= HDR_LAST; k++) send_byte(k == pad_at ? pad_val : 8'h00);
  endtask

  task automatic send_tag(input logic [7:0] kind, input int size, input logic [7:0] lead,
                          input logic [31:0] trailer);
    int k;
    send_byte(kind);
    send_byte(size[23:16]);
    send_byte(size[15:8]);
    send_byte(size[7:0]);
    for (k = 4; k <= TAG_HDR_LAST; k++) send_byte(8'($urandom));
    for (k = 0; k < size; k++) send_byte(k == 0 ? lead : 8'($urandom));
    for (k = 3; k >= 0; k--) send_byte(trailer[8*k +: 8]);
  endtask

  function automatic void note_mismatch(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
    errors++;
    if (errors <= MAX_SHOWN)
      $display("%0t: %s expected %0h got %0h", $time, field, want, got);
  endfunction

  task automatic compare_report();
    unit_report_t want;
    if (unit_reports.size() == 0) begin
      note_mismatch("unexpected result beat, outcome", '0, outcome);
      return;
    end
    want = unit_reports.pop_front();
    reports_seen++;
    if (want.outcome == OUT_HDR_OK || want.outcome == OUT_HDR_BAD) hdr_seen++;
    else tag_seen++;
    if (want.keyframe) key_seen++;
    if (outcome !== want.outcome) note_mismatch("outcome", want.outcome, outcome);
    if (tag_type !== want.tag_type) note_mismatch("tag_type", want.tag_type, tag_type);
    if (data_size !== want.data_size) note_mismatch("data_size", want.data_size, data_size);
    if (keyframe !== want.keyframe) note_mismatch("keyframe", want.keyframe, keyframe);
    if (stream_version !== want.version)
      note_mismatch("stream_version", want.version, stream_version);
    if (stream_flags !== want.flags) note_mismatch("stream_flags", want.flags, stream_flags);
    if (trailer_size !== want.trailer) note_mismatch("trailer_size", want.trailer, trailer_size);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) compare_report();
  end

  // Result side: random pop gaps, plus a long hold when a test asks for one
  initial begin : result_sink
    int gap;
    wait (rst_ni === 1'b1);
    forever begin
      if (rx_hold > 0) begin
        pop <= 1'b0;
        repeat (rx_hold) @(posedge clk_i);
        rx_hold = 0;
      end else begin
        gap = idle_gap(rx_idle);
        if (gap > 0) begin
          pop <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        pop <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  task automatic test_stream_header();
    send_flv_header(8'hff, 8'h00, HDR_MARK, 0, 8'h00);
  endtask

  task automatic test_video_keyframe();
    send_tag(VIDEO_TAG, 1, {KEY_FRAME, 4'h7}, good_trailer(1));
  endtask

  task automatic test_random_units();
    int          byte_goal;
    int          report_goal;
    int          r;
    int          size;
    logic [7:0]  kind;
    logic [7:0]  lead;
    byte_goal   = bytes_sent + 400;
    report_goal = reports_made + 12;
    while (bytes_sent < byte_goal || reports_made < report_goal) begin
      // alternate stretches with and without idling on either side
      if ($urandom_range(0, 9) == 0) tx_idle = !tx_idle;
      if ($urandom_range(0, 9) == 0) rx_idle = !rx_idle;
      if ($urandom_range(0, 99) < 12) begin
        send_flv_header(8'($urandom), 8'($urandom), HDR_MARK, 0, 8'h00);
      end else begin
        r = $urandom_range(0, 99);
        if (r < 40)      kind = VIDEO_TAG;
        else if (r < 60) kind = AUDIO_TAG;
        else if (r < 70) kind = SCRIPT_TAG;
        else if (r < 78) kind = CHAR_F;
        else             kind = 8'($urandom);
        r = $urandom_range(0, 99);
        if (r < 70)      size = $urandom_range(0, 8);
        else if (r < 98) size = $urandom_range(9, 40);
        else             size = $urandom_range(100, 300);
        lead = $urandom_range(0, 1) ? {KEY_FRAME, 4'($urandom)} : 8'($urandom);
        send_tag(kind, size, lead, good_trailer(size));
      end
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  task automatic test_result_backpressure();
    tx_idle = 1'b0;
    rx_hold = 150;
    repeat (10) send_tag(8'($urandom), 0, 8'h00, good_trailer(0));
    tx_idle = 1'b1;
  endtask

  // One broken unit per run: the block halts and drops everything after it
  task automatic test_halt_on_error();
    int size;
    closing_break = break_e'($urandom_range(0, 3));
    size          = $urandom_range(0, 8);
    case (closing_break)
      BREAK_MARK:
        send_flv_header(8'($urandom), 8'($urandom), HDR_MARK ^ 8'($urandom_range(1, 255)),
                        0, 8'h00);
      BREAK_PAD:
        send_flv_header(8'($urandom), 8'($urandom), HDR_MARK, $urandom_range(9, HDR_LAST),
                        8'($urandom_range(1, 255)));
      BREAK_TRAILER:
        send_tag(VIDEO_TAG, size, {KEY_FRAME, 4'($urandom)},
                 good_trailer(size) ^ (32'd1 << $urandom_range(0, 31)));
      default:
        send_tag(VIDEO_TAG, size, 8'($urandom), 32'hffff_ffff);
    endcase
    repeat (30) send_byte(8'($urandom));
    send_tag(VIDEO_TAG, 0, 8'h00, good_trailer(0));
  endtask

  initial begin : watchdog
    #2_000_000;
    $display("flv_tag_deframer: mismatch");
    $finish;
  end

  initial begin : main
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_stream_header();
    test_video_keyframe();
    test_random_units();
    test_result_backpressure();
    test_halt_on_error();
    push <= 1'b0;
    while (unit_reports.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("Sent %0d bytes, checked %0d results: %0d stream headers, %0d tags, %0d keyframes",
             bytes_sent, reports_seen, hdr_seen, tag_seen, key_seen);
    $display("Closed with %s, then %0d bytes dropped while halted",
             closing_break.name(), dropped_bytes);
    if (errors == 0) begin
      $display("flv_tag_deframer: match");
    end else begin
      $display("%0d mismatches in total", errors);
      $display("flv_tag_deframer: mismatch");
    end
    $finish;
  end

endmodule

### filelist.f
hdl/flvd_pkg.sv
hdl/flvd_front.sv
hdl/flvd_queue.sv
hdl/flvd_back.sv
hdl/flv_tag_deframer.sv
dv/testbench.sv
